@@ hw/rtl/fdr_pkg.sv @@
package fdr_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int COS_W = 16;
  localparam int ETA_W = 16;
  localparam int OUT_W = 15;
  localparam int ADDR_W = 3;
  localparam int REG_SEL_BIT = 2;
  localparam int DATA_W = 32;

  localparam logic [COS_W-1:0] COS_ONE = 16'd16384;
  localparam logic [OUT_W-1:0] OUT_ONE = 15'd16384;
  localparam logic [ETA_W-1:0] ETA_I_RST = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_T_RST = 16'd6144;

  typedef enum logic {
    REG_ETA_INCIDENT = 1'b0,
    REG_ETA_TRANSMIT = 1'b1
  } reg_idx_t;

endpackage

@@ hw/rtl/fdr_if.sv @@
interface fdr_in_if;
  import fdr_pkg::*;
  logic valid;
  logic ready;
  logic signed [COS_W-1:0] cos_incident;
  modport source (output valid, output cos_incident, input ready);
  modport sink (input valid, input cos_incident, output ready);
endinterface

interface fdr_out_if;
  import fdr_pkg::*;
  logic valid;
  logic ready;
  logic [OUT_W-1:0] reflectance;
  logic total_internal;
  modport source (output valid, output reflectance, output total_internal, input ready);
  modport sink (input valid, input reflectance, input total_internal, output ready);
endinterface

@@ hw/rtl/fdr_isqrt.sv @@
module fdr_isqrt #(
  parameter int N = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*N-1:0]    v,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [N-1:0]      root,
  output logic [SIDE_W-1:0] side_out
);

  logic [2*N-1:0]    v_s    [N+1];
  logic [N:0]        rem_s  [N+1];
  logic [N-1:0]      root_s [N+1];
  logic              vld_s  [N+1];
  logic [SIDE_W-1:0] side_s [N+1];

  assign v_s[0] = v;
  assign rem_s[0] = '0;
  assign root_s[0] = '0;
  assign vld_s[0] = in_valid;
  assign side_s[0] = side_in;

  // one result bit per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N+2:0] t;
    logic [N+2:0] trial;
    logic         ge;

    always_comb begin
      t = {rem_s[k], v_s[k][2*N-1 -: 2]};
      trial = (N+3)'({root_s[k], 2'b01});
      ge = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_s[k+1] <= v_s[k] << 2;
        rem_s[k+1] <= ge ? (N+1)'(t - trial) : (N+1)'(t);
        root_s[k+1] <= {root_s[k][N-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_valid = vld_s[N];
  assign root = root_s[N];
  assign side_out = side_s[N];

endmodule

@@ hw/rtl/fdr_div.sv @@
module fdr_div #(
  parameter int W = 16,
  parameter int Q = 14,
  parameter int LANES = 1,
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][W-1:0]   rem0,
  input  logic [LANES-1:0][W-1:0]   den,
  input  logic [LANES-1:0][Q-1:0]   low,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [LANES-1:0][Q-1:0]   quo,
  output logic [SIDE_W-1:0]         side_out
);

  logic [LANES-1:0][W-1:0] rem_s  [Q+1];
  logic [LANES-1:0][W-1:0] den_s  [Q+1];
  logic [LANES-1:0][Q-1:0] low_s  [Q+1];
  logic [LANES-1:0][Q-1:0] quo_s  [Q+1];
  logic                    vld_s  [Q+1];
  logic [SIDE_W-1:0]       side_s [Q+1];

  assign rem_s[0] = rem0;
  assign den_s[0] = den;
  assign low_s[0] = low;
  assign quo_s[0] = '0;
  assign vld_s[0] = in_valid;
  assign side_s[0] = side_in;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [LANES-1:0][W-1:0] nrem;
    logic [LANES-1:0]        qb;
    logic [W:0]              t;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem_s[k][l], low_s[k][l][Q-1]};
        qb[l] = (t >= {1'b0, den_s[k][l]});
        nrem[l] = qb[l] ? W'(t - {1'b0, den_s[k][l]}) : W'(t);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k+1] <= 1'b0;
      end else if (en) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= nrem;
        den_s[k+1] <= den_s[k];
        side_s[k+1] <= side_s[k];
        for (int l = 0; l < LANES; l++) begin
          low_s[k+1][l] <= low_s[k][l] << 1;
          quo_s[k+1][l] <= {quo_s[k][l][Q-2:0], qb[l]};
        end
      end
    end
  end

  assign out_valid = vld_s[Q];
  assign quo = quo_s[Q];
  assign side_out = side_s[Q];

endmodule

@@ hw/rtl/dielectric_fresnel_reflectance.sv @@
// Dielectric Fresnel reflectance, one beat in and one beat out per item.
// cosine: signed Q2.14 incident cosine, saturated to plus or minus one; a
//   negative cosine swaps the two indices.
// result: unsigned Q1.14 reflectance and a total internal reflection flag;
//   with the flag set the reflectance is exactly one.
// APB port: eta_incident at byte 0, eta_transmit at byte 4, Q4.12 each.
//   Write them only while no item is in flight.
// Throughput: one item per cycle while result is not stalled, every stage advances together.
// Pipeline: from accept to result valid, two pipelined square roots of
//   FRAC_BITS+1 stages and two pipelined restoring dividers of FRAC_BITS
//   stages, plus eight arithmetic register stages.
// Reset: clears every stage valid bit, result valid included, and loads
//   the indices with 1.0 and 1.5.
// Stall: while result is valid and not taken the whole pipeline holds and
//   cosine ready is low; nothing is lost or repeated.
module dielectric_fresnel_reflectance #(
  parameter int FRAC_BITS = fdr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  fdr_in_if.sink                      cosine,
  fdr_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdr_pkg::ADDR_W-1:0]  paddr,
  input  logic [fdr_pkg::DATA_W-1:0]  pwdata,
  output logic [fdr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import fdr_pkg::*;

  localparam int N = FRAC_BITS + 1;
  localparam int SQ_W = 2 * N;
  localparam int PW = ETA_W + N;
  localparam int DEN_W = PW + 1;
  localparam int SIDE_W = 1 + 2 * ETA_W + N;
  localparam int SUM_W = SQ_W + 1;
  localparam int RW = SUM_W - (FRAC_BITS + 1);
  localparam logic [N-1:0] ONE = N'(1) << FRAC_BITS;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

  logic [ETA_W-1:0] eta_i;
  logic [ETA_W-1:0] eta_t;
  logic             en;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_i <= ETA_I_RST;
      eta_t <= ETA_T_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[REG_SEL_BIT]))
        REG_ETA_INCIDENT: eta_i <= pwdata[ETA_W-1:0];
        REG_ETA_TRANSMIT: eta_t <= pwdata[ETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[REG_SEL_BIT]))
      REG_ETA_INCIDENT: prdata = DATA_W'(eta_i);
      REG_ETA_TRANSMIT: prdata = DATA_W'(eta_t);
      default: prdata = '0;
    endcase
  end

  assign en = !result.valid || result.ready;
  assign cosine.ready = en;

  // stage 0: saturate, swap, rescale
  logic signed [COS_W-1:0] x;
  logic                    neg;
  logic [COS_W-2:0]        mag;
  logic [N-1:0]            ci_in;
  logic                    v0, tir0;
  logic [N-1:0]            ci0;
  logic [ETA_W-1:0]        ei0, et0;

  always_comb begin
    x = cosine.cos_incident;
    neg = x[COS_W-1];
    if (x > $signed(COS_ONE) || x < -$signed(COS_ONE)) begin
      mag = (COS_W-1)'(COS_ONE);
    end else if (neg) begin
      mag = (COS_W-1)'(-x);
    end else begin
      mag = (COS_W-1)'(x);
    end
  end

  if (FRAC_BITS >= 14) begin : g_up
    assign ci_in = N'(mag) << (FRAC_BITS - 14);
  end else begin : g_dn
    assign ci_in = N'(mag >> (14 - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= cosine.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci0 <= ci_in;
      ei0 <= neg ? eta_t : eta_i;
      et0 <= neg ? eta_i : eta_t;
      tir0 <= neg ? (eta_i == '0) : (eta_t == '0);
    end
  end

  // stage 1: 1 - cos^2
  logic             v1, tir1;
  logic [N-1:0]     ci1;
  logic [ETA_W-1:0] ei1, et1;
  logic [SQ_W-1:0]  sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1 <= ONE_SQ - SQ_W'(ci0) * SQ_W'(ci0);
      ci1 <= ci0;
      ei1 <= ei0;
      et1 <= et0;
      tir1 <= tir0;
    end
  end

  logic              va;
  logic [N-1:0]      sin_i;
  logic [SIDE_W-1:0] sa;

  fdr_isqrt #(.N(N), .SIDE_W(SIDE_W)) u_sqrt_sin (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .v(sq1),
    .side_in({tir1, ei1, et1, ci1}),
    .out_valid(va), .root(sin_i), .side_out(sa)
  );

  // stage 2: eta_i * sin_i
  logic             v2, tir2;
  logic [N-1:0]     ci2;
  logic [ETA_W-1:0] ei2, et2;
  logic [PW-1:0]    p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {tir2, ei2, et2, ci2} <= sa;
      p2 <= PW'(sa[SIDE_W-2 -: ETA_W]) * PW'(sin_i);
    end
  end

  // snell: sin_t = eta_i * sin_i / eta_t, overflow means total internal
  logic [PW-FRAC_BITS-1:0] p_hi;
  logic                    tir_d;
  logic                    vd;
  logic [0:0][FRAC_BITS-1:0] sin_t;
  logic [SIDE_W-1:0]       sd;

  assign p_hi = p2[PW-1:FRAC_BITS];
  assign tir_d = tir2 || (p_hi >= (PW-FRAC_BITS)'(et2));

  fdr_div #(.W(ETA_W), .Q(FRAC_BITS), .LANES(1), .SIDE_W(SIDE_W)) u_div_snell (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .rem0(tir_d ? ETA_W'(0) : ETA_W'(p_hi)),
    .den(et2), .low(p2[FRAC_BITS-1:0]),
    .side_in({tir_d, ei2, et2, ci2}),
    .out_valid(vd), .quo(sin_t), .side_out(sd)
  );

  // stage 3: 1 - sin_t^2
  logic             v3, tir3;
  logic [N-1:0]     ci3;
  logic [ETA_W-1:0] ei3, et3;
  logic [SQ_W-1:0]  sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {tir3, ei3, et3, ci3} <= sd;
      sq3 <= ONE_SQ - SQ_W'(sin_t[0]) * SQ_W'(sin_t[0]);
    end
  end

  logic              vb;
  logic [N-1:0]      cos_t;
  logic [SIDE_W-1:0] sb;

  fdr_isqrt #(.N(N), .SIDE_W(SIDE_W)) u_sqrt_cos (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .v(sq3),
    .side_in({tir3, ei3, et3, ci3}),
    .out_valid(vb), .root(cos_t), .side_out(sb)
  );

  // stage 4: amplitude ratio terms
  logic             v4, tir4;
  logic [N-1:0]     ci_b;
  logic [ETA_W-1:0] ei_b, et_b;
  logic             tir_b;
  logic [PW-1:0]    a_par, b_par, a_perp, b_perp;

  assign {tir_b, ei_b, et_b, ci_b} = sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir4 <= tir_b;
      a_par <= PW'(et_b) * PW'(ci_b);
      b_par <= PW'(ei_b) * PW'(cos_t);
      a_perp <= PW'(ei_b) * PW'(ci_b);
      b_perp <= PW'(et_b) * PW'(cos_t);
    end
  end

  // stage 5: |a-b| and a+b
  logic [DEN_W-1:0] num_par, den_par, num_perp, den_perp;
  logic             v5, tir5, ge_par, ge_perp;
  logic [DEN_W-1:0] num5_par, den5_par, num5_perp, den5_perp;

  always_comb begin
    den_par = DEN_W'(a_par) + DEN_W'(b_par);
    num_par = (a_par >= b_par) ? DEN_W'(a_par - b_par) : DEN_W'(b_par - a_par);
    den_perp = DEN_W'(a_perp) + DEN_W'(b_perp);
    num_perp = (a_perp >= b_perp) ? DEN_W'(a_perp - b_perp) : DEN_W'(b_perp - a_perp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir5 <= tir4;
      ge_par <= (num_par >= den_par);
      ge_perp <= (num_perp >= den_perp);
      num5_par <= (num_par >= den_par) ? '0 : num_par;
      num5_perp <= (num_perp >= den_perp) ? '0 : num_perp;
      den5_par <= den_par;
      den5_perp <= den_perp;
    end
  end

  logic                      vf;
  logic [1:0][FRAC_BITS-1:0] rq;
  logic [2:0]                sf;

  fdr_div #(.W(DEN_W), .Q(FRAC_BITS), .LANES(2), .SIDE_W(3)) u_div_ratio (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5),
    .rem0({num5_perp, num5_par}), .den({den5_perp, den5_par}),
    .low('0), .side_in({tir5, ge_perp, ge_par}),
    .out_valid(vf), .quo(rq), .side_out(sf)
  );

  // stage 6: squared ratios
  logic            v6, tir6;
  logic [N-1:0]    r_par, r_perp;
  logic [SQ_W-1:0] sq_par, sq_perp;

  assign r_par = sf[0] ? ONE : N'(rq[0]);
  assign r_perp = sf[1] ? ONE : N'(rq[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir6 <= sf[2];
      sq_par <= SQ_W'(r_par) * SQ_W'(r_par);
      sq_perp <= SQ_W'(r_perp) * SQ_W'(r_perp);
    end
  end

  // stage 7: mean, round, convert to Q1.14
  logic [SUM_W-1:0] sum;
  logic [RW-1:0]    rmean;
  logic [16:0]      cvt;

  assign sum = SUM_W'(sq_par) + SUM_W'(sq_perp) + SUM_W'(ONE);
  assign rmean = RW'(sum >> (FRAC_BITS + 1));

  if (FRAC_BITS > 14) begin : g_cvt_dn
    logic [RW:0] rr;
    assign rr = (RW+1)'(rmean) + ((RW+1)'(1) << (FRAC_BITS - 15));
    assign cvt = 17'(rr >> (FRAC_BITS - 14));
  end else begin : g_cvt_up
    assign cvt = 17'(rmean) << (14 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.total_internal <= tir6;
      if (tir6 || cvt > 17'(OUT_ONE)) begin
        result.reflectance <= OUT_ONE;
      end else begin
        result.reflectance <= OUT_W'(cvt);
      end
    end
  end

`ifndef ASSERT_OFF
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.total_internal |-> result.reflectance == OUT_ONE)
    else $error("total internal reflection without unit reflectance");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.reflectance <= OUT_ONE)
    else $error("reflectance above one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid && !v0 && !v6)
    else $error("valid bits survive reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v6) && (!v6 || $stable(tir6)))
    else $error("pipeline moved during stall");
`endif

endmodule
